FILE: src/pascal_subset_lexer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lexer checker
// Wrap the clocking and reset gating shared by every concurrent check.
// ----------------------------------------------------------------------------
`ifndef PASCAL_SUBSET_LEXER_ASSERT_SVH
`define PASCAL_SUBSET_LEXER_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define PSL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Check a condition in the cycle after its trigger.
`define PSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

FILE: src/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types, token kinds and character helpers for the lexer.
// ----------------------------------------------------------------------------
package psl_pkg;

    localparam int KW_MAX_LEN  = 9;
    localparam int LINE_BITS   = 20;
    localparam int LENGTH_BITS = 16;
    localparam int OFFSET_BITS = 32;
    localparam int KIND_BITS   = 6;
    localparam int WB_IDX_W    = $clog2(KW_MAX_LEN);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int NUM_KW      = 27;

    localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_TOP  = '1;

    localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd0;
    localparam logic [KIND_BITS-1:0] K_INT     = 6'd28;
    localparam logic [KIND_BITS-1:0] K_REAL    = 6'd29;
    localparam logic [KIND_BITS-1:0] K_CHAR    = 6'd30;
    localparam logic [KIND_BITS-1:0] K_STRING  = 6'd31;
    localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd32;
    localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd33;
    localparam logic [KIND_BITS-1:0] K_TIMES   = 6'd34;
    localparam logic [KIND_BITS-1:0] K_RDIV    = 6'd35;
    localparam logic [KIND_BITS-1:0] K_EQL     = 6'd36;
    localparam logic [KIND_BITS-1:0] K_NEQ     = 6'd37;
    localparam logic [KIND_BITS-1:0] K_LSS     = 6'd38;
    localparam logic [KIND_BITS-1:0] K_LEQ     = 6'd39;
    localparam logic [KIND_BITS-1:0] K_GTR     = 6'd40;
    localparam logic [KIND_BITS-1:0] K_GEQ     = 6'd41;
    localparam logic [KIND_BITS-1:0] K_BECOMES = 6'd42;
    localparam logic [KIND_BITS-1:0] K_LPAR    = 6'd43;
    localparam logic [KIND_BITS-1:0] K_RPAR    = 6'd44;
    localparam logic [KIND_BITS-1:0] K_LBRACK  = 6'd45;
    localparam logic [KIND_BITS-1:0] K_RBRACK  = 6'd46;
    localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd47;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd48;
    localparam logic [KIND_BITS-1:0] K_PERIOD  = 6'd49;
    localparam logic [KIND_BITS-1:0] K_COLON   = 6'd50;
    localparam logic [KIND_BITS-1:0] K_UNKNOWN = 6'd51;
    localparam logic [KIND_BITS-1:0] K_END     = 6'd52;

    typedef logic [KW_MAX_LEN*8-1:0] kw_text_t;
    typedef logic [KW_MAX_LEN-1:0][7:0] word_buf_t;

    // Keyword text, first character in the highest used byte.
    localparam kw_text_t KW_TEXT [NUM_KW] = '{
        "not", "div", "mod", "and", "or", "const", "type", "var", "function",
        "procedure", "array", "record", "program", "begin", "if", "case",
        "repeat", "while", "for", "end", "else", "until", "of", "do", "to",
        "downto", "then"
    };
    localparam int KW_LEN [NUM_KW] = '{
        3, 3, 3, 3, 2, 5, 4, 3, 8, 9, 5, 6, 7, 5, 2, 4, 6, 5, 3, 3, 4, 5, 2,
        2, 2, 6, 4
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   token_kind;
        logic [LINE_BITS-1:0]   start_line;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [LENGTH_BITS-1:0] token_length;
        logic                   unclosed_comment;
        logic                   last;
    } token_t;

    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } entry_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] grow(input logic [LENGTH_BITS-1:0] len);
        return (len != LEN_TOP) ? len + 1'b1 : len;
    endfunction

    // Parallel compare of the buffered word against every keyword.
    function automatic logic [KIND_BITS-1:0] kw_lookup(input word_buf_t buf_in,
                                                       input logic [LENGTH_BITS-1:0] len);
        logic [KIND_BITS-1:0] kind;
        logic                 hit;
        kind = K_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            hit = (len == LENGTH_BITS'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (i < KW_LEN[k] && buf_in[i] != KW_TEXT[k][(KW_LEN[k]-1-i)*8 +: 8])
                    hit = 1'b0;
            end
            if (hit)
                kind = KIND_BITS'(k + 1);
        end
        return kind;
    endfunction

endpackage

FILE: src/psl_front.sv
// ----------------------------------------------------------------------------
// psl_front
// Byte scanner: classify each beat and build a queue entry of one or two tokens.
// ----------------------------------------------------------------------------
module psl_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  psl_pkg::in_item_t  item,
    output logic               wr_en,
    output psl_pkg::entry_t    wr_data
);

    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_WORD      = 4'd1;
    localparam logic [3:0] M_INT       = 4'd2;
    localparam logic [3:0] M_INT_DOT   = 4'd3;
    localparam logic [3:0] M_REAL      = 4'd4;
    localparam logic [3:0] M_BAD       = 4'd5;
    localparam logic [3:0] M_DOT       = 4'd6;
    localparam logic [3:0] M_STR       = 4'd7;
    localparam logic [3:0] M_BRACE     = 4'd8;
    localparam logic [3:0] M_LPAREN    = 4'd9;
    localparam logic [3:0] M_PCMT      = 4'd10;
    localparam logic [3:0] M_PCMT_STAR = 4'd11;
    localparam logic [3:0] M_EQ        = 4'd12;
    localparam logic [3:0] M_COLON     = 4'd13;
    localparam logic [3:0] M_LT        = 4'd14;
    localparam logic [3:0] M_GT        = 4'd15;

    logic [3:0]                         mode_reg, mode_next;
    logic [psl_pkg::LINE_BITS-1:0]      line_reg, line_next;
    logic [psl_pkg::OFFSET_BITS-1:0]    off_reg, off_next;
    logic [psl_pkg::LINE_BITS-1:0]      tsl_reg, tsl_next;
    logic [psl_pkg::OFFSET_BITS-1:0]    tso_reg, tso_next;
    logic [psl_pkg::LENGTH_BITS-1:0]    len_reg, len_next;
    logic [1:0]                         qc_reg, qc_next;
    psl_pkg::word_buf_t                 wb_reg;

    logic                               wb_we;
    logic [psl_pkg::WB_IDX_W-1:0]       wb_idx;
    logic [7:0]                         c;
    logic                               p_en, p_unc, x_en, disp, bad_ch;
    logic [psl_pkg::KIND_BITS-1:0]      p_kind;
    logic [psl_pkg::LENGTH_BITS-1:0]    p_len, len1;
    psl_pkg::token_t                    x_tok, p_tok;

    always_comb
    begin
        c         = item.char_code;
        mode_next = mode_reg;
        line_next = line_reg;
        off_next  = off_reg;
        tsl_next  = tsl_reg;
        tso_next  = tso_reg;
        len_next  = len_reg;
        qc_next   = qc_reg;
        wb_we     = 1'b0;
        wb_idx    = len_reg[psl_pkg::WB_IDX_W-1:0];
        p_en      = 1'b0;
        p_kind    = psl_pkg::K_UNKNOWN;
        p_unc     = 1'b0;
        p_len     = len_reg;
        x_en      = 1'b0;
        x_tok     = '0;
        disp      = 1'b0;
        len1      = psl_pkg::grow(len_reg);
        bad_ch    = psl_pkg::is_alpha(c) || psl_pkg::is_digit(c) || c == "." ||
                    c == "+" || c == "-" || c == "/";

        if (item.end_of_input)
        begin
            p_en = 1'b1;
            case (mode_reg)
                M_WORD:      p_kind = psl_pkg::kw_lookup(wb_reg, len_reg);
                M_INT:       p_kind = psl_pkg::K_INT;
                M_INT_DOT:
                begin
                    p_len    = len1;
                    len_next = len1;
                end
                M_REAL:      p_kind = psl_pkg::K_REAL;
                M_DOT:       p_kind = psl_pkg::K_PERIOD;
                M_BRACE, M_PCMT, M_PCMT_STAR: p_unc = 1'b1;
                M_LPAREN:    p_kind = psl_pkg::K_LPAR;
                M_COLON:     p_kind = psl_pkg::K_COLON;
                M_LT:        p_kind = psl_pkg::K_LSS;
                M_GT:        p_kind = psl_pkg::K_GTR;
                M_BAD, M_STR, M_EQ: p_kind = psl_pkg::K_UNKNOWN;
                default:     p_en = 1'b0;
            endcase
            x_en      = 1'b1;
            x_tok     = '{psl_pkg::K_END, line_reg, off_reg, '0, 1'b0, 1'b1};
            mode_next = M_IDLE;
        end
        else
        begin
            case (mode_reg)
                M_WORD:
                    if (psl_pkg::is_alpha(c) || psl_pkg::is_digit(c))
                    begin
                        wb_we    = (len_reg < psl_pkg::LENGTH_BITS'(psl_pkg::KW_MAX_LEN));
                        len_next = len1;
                    end
                    else
                    begin
                        p_en   = 1'b1;
                        p_kind = psl_pkg::kw_lookup(wb_reg, len_reg);
                        disp   = 1'b1;
                    end
                M_INT:
                    if (psl_pkg::is_digit(c))
                        len_next = len1;
                    else if (c == ".")
                        mode_next = M_INT_DOT;
                    else
                    begin
                        p_en   = 1'b1;
                        p_kind = psl_pkg::K_INT;
                        disp   = 1'b1;
                    end
                M_INT_DOT:
                    if (c == ".")
                    begin
                        // Range: digits, then a period for the first dot.
                        p_en      = 1'b1;
                        p_kind    = psl_pkg::K_INT;
                        x_en      = 1'b1;
                        x_tok     = '{psl_pkg::K_PERIOD, line_reg, off_reg - 1'b1,
                                      psl_pkg::LENGTH_BITS'(1), 1'b0, 1'b1};
                        mode_next = M_DOT;
                        tsl_next  = line_reg;
                        tso_next  = off_reg;
                        len_next  = psl_pkg::LENGTH_BITS'(1);
                    end
                    else if (psl_pkg::is_digit(c))
                    begin
                        len_next  = psl_pkg::grow(len1);
                        mode_next = M_REAL;
                    end
                    else if (bad_ch)
                    begin
                        len_next  = psl_pkg::grow(len1);
                        mode_next = M_BAD;
                    end
                    else
                    begin
                        p_en     = 1'b1;
                        p_len    = len1;
                        len_next = len1;
                        disp     = 1'b1;
                    end
                M_REAL:
                    if (psl_pkg::is_digit(c))
                        len_next = len1;
                    else if (c == "." || psl_pkg::is_alpha(c))
                    begin
                        len_next  = len1;
                        mode_next = M_BAD;
                    end
                    else
                    begin
                        p_en   = 1'b1;
                        p_kind = psl_pkg::K_REAL;
                        disp   = 1'b1;
                    end
                M_BAD:
                    if (bad_ch)
                        len_next = len1;
                    else
                    begin
                        p_en = 1'b1;
                        disp = 1'b1;
                    end
                M_DOT:
                    if (psl_pkg::is_digit(c))
                    begin
                        len_next  = len1;
                        mode_next = M_BAD;
                    end
                    else
                    begin
                        p_en   = 1'b1;
                        p_kind = psl_pkg::K_PERIOD;
                        disp   = 1'b1;
                    end
                M_STR:
                begin
                    len_next = len1;
                    if (c == 8'h27)
                    begin
                        p_en      = 1'b1;
                        p_len     = len1;
                        p_kind    = (qc_reg == 2'd0) ? psl_pkg::K_UNKNOWN :
                                    (qc_reg == 2'd1) ? psl_pkg::K_CHAR : psl_pkg::K_STRING;
                        mode_next = M_IDLE;
                    end
                    else if (qc_reg != 2'd2)
                        qc_next = qc_reg + 2'd1;
                end
                M_BRACE:
                begin
                    len_next = len1;
                    if (c == "}")
                        mode_next = M_IDLE;
                end
                M_LPAREN:
                    if (c == "*")
                    begin
                        len_next  = len1;
                        mode_next = M_PCMT;
                    end
                    else
                    begin
                        p_en   = 1'b1;
                        p_kind = psl_pkg::K_LPAR;
                        disp   = 1'b1;
                    end
                M_PCMT:
                begin
                    len_next = len1;
                    if (c == "*")
                        mode_next = M_PCMT_STAR;
                end
                M_PCMT_STAR:
                begin
                    len_next = len1;
                    if (c == ")")
                        mode_next = M_IDLE;
                    else if (c != "*")
                        mode_next = M_PCMT;
                end
                M_EQ, M_COLON, M_LT, M_GT:
                begin
                    p_en = 1'b1;
                    if ((mode_reg == M_EQ && c == "=") || (mode_reg == M_COLON && c == "=") ||
                        (mode_reg == M_LT && (c == ">" || c == "=")) ||
                        (mode_reg == M_GT && c == "="))
                    begin
                        p_len     = len1;
                        len_next  = len1;
                        mode_next = M_IDLE;
                        case (mode_reg)
                            M_EQ:    p_kind = psl_pkg::K_EQL;
                            M_COLON: p_kind = psl_pkg::K_BECOMES;
                            M_LT:    p_kind = (c == ">") ? psl_pkg::K_NEQ : psl_pkg::K_LEQ;
                            default: p_kind = psl_pkg::K_GEQ;
                        endcase
                    end
                    else
                    begin
                        disp = 1'b1;
                        case (mode_reg)
                            M_EQ:    p_kind = psl_pkg::K_UNKNOWN;
                            M_COLON: p_kind = psl_pkg::K_COLON;
                            M_LT:    p_kind = psl_pkg::K_LSS;
                            default: p_kind = psl_pkg::K_GTR;
                        endcase
                    end
                end
                default: disp = 1'b1;
            endcase

            if (disp)
            begin
                mode_next = M_IDLE;
                if (!psl_pkg::is_space(c))
                begin
                    tsl_next = line_reg;
                    tso_next = off_reg;
                    len_next = psl_pkg::LENGTH_BITS'(1);
                    x_tok    = '{psl_pkg::K_UNKNOWN, line_reg, off_reg,
                                 psl_pkg::LENGTH_BITS'(1), 1'b0, 1'b1};
                    if (psl_pkg::is_alpha(c))
                    begin
                        mode_next = M_WORD;
                        wb_we     = 1'b1;
                        wb_idx    = '0;
                    end
                    else if (psl_pkg::is_digit(c))
                        mode_next = M_INT;
                    else
                    begin
                        case (c)
                            8'h27: begin mode_next = M_STR; qc_next = 2'd0; end
                            "{":   mode_next = M_BRACE;
                            "(":   mode_next = M_LPAREN;
                            "=":   mode_next = M_EQ;
                            ":":   mode_next = M_COLON;
                            "<":   mode_next = M_LT;
                            ">":   mode_next = M_GT;
                            ".":   mode_next = M_DOT;
                            "+":   begin x_en = 1'b1; x_tok.token_kind = psl_pkg::K_PLUS;   end
                            "-":   begin x_en = 1'b1; x_tok.token_kind = psl_pkg::K_MINUS;  end
                            "*":   begin x_en = 1'b1; x_tok.token_kind = psl_pkg::K_TIMES;  end
                            "/":   begin x_en = 1'b1; x_tok.token_kind = psl_pkg::K_RDIV;   end
                            ")":   begin x_en = 1'b1; x_tok.token_kind = psl_pkg::K_RPAR;   end
                            "[":   begin x_en = 1'b1; x_tok.token_kind = psl_pkg::K_LBRACK; end
                            "]":   begin x_en = 1'b1; x_tok.token_kind = psl_pkg::K_RBRACK; end
                            ",":   begin x_en = 1'b1; x_tok.token_kind = psl_pkg::K_COMMA;  end
                            ";":   begin x_en = 1'b1; x_tok.token_kind = psl_pkg::K_SEMI;   end
                            default: x_en = 1'b1;
                        endcase
                    end
                end
            end

            if (c == 8'h0A && line_reg != psl_pkg::LINE_TOP)
                line_next = line_reg + 1'b1;
            off_next = off_reg + 1'b1;
        end

        p_tok   = '{p_kind, tsl_reg, tso_reg, p_len, p_unc, !x_en};
        wr_en   = accept && (p_en || x_en);
        wr_data = '{p_en && x_en, p_en ? p_tok : x_tok, x_tok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            line_reg <= psl_pkg::LINE_BITS'(1);
            off_reg  <= '0;
            tsl_reg  <= psl_pkg::LINE_BITS'(1);
            tso_reg  <= '0;
            len_reg  <= '0;
            qc_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            off_reg  <= off_next;
            tsl_reg  <= tsl_next;
            tso_reg  <= tso_next;
            len_reg  <= len_next;
            qc_reg   <= qc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wb_we)
            wb_reg[wb_idx] <= psl_pkg::to_lower(c);
    end

endmodule

FILE: src/psl_queue.sv
// ----------------------------------------------------------------------------
// psl_queue
// Short entry queue between the scanner and the token serialiser.
// ----------------------------------------------------------------------------
module psl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  psl_pkg::entry_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output psl_pkg::entry_t rd_data,
    output logic            empty
);

    psl_pkg::entry_t               slot_reg [psl_pkg::QUEUE_DEPTH];
    logic [psl_pkg::QPTR_W-1:0]    wp_reg, rp_reg;
    logic [psl_pkg::QPTR_W:0]      cnt_reg;

    assign full    = (cnt_reg == (psl_pkg::QPTR_W+1)'(psl_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (psl_pkg::QPTR_W+1)'(wr_en) - (psl_pkg::QPTR_W+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wp_reg] <= wr_data;
    end

endmodule

FILE: src/psl_back.sv
// ----------------------------------------------------------------------------
// psl_back
// Serialiser: hand out the tokens of the head entry one beat at a time.
// ----------------------------------------------------------------------------
module psl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  psl_pkg::entry_t head,
    input  logic            q_empty,
    output logic            q_rd_en,
    input  logic            pop,
    output logic            empty,
    output psl_pkg::token_t token
);

    logic sel_reg;

    assign empty   = q_empty;
    assign token   = sel_reg ? head.second : head.first;
    // Drop the entry once its final token is taken.
    assign q_rd_en = pop && !q_empty && (sel_reg || !head.two);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else if (pop && !q_empty)
            sel_reg <= !sel_reg && head.two;
    end

endmodule

FILE: src/pascal_subset_lexer.sv
// ----------------------------------------------------------------------------
// pascal_subset_lexer
// Streaming lexer for a small Pascal-like language, one source byte a beat.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while full is low; a beat causes zero, one
// or two tokens, which come out of a four-entry queue through empty/pop, one
// token a cycle while pop is high. Input rate is one byte per cycle; the
// output side moves one token per cycle, so a long run of two-token beats
// fills the queue and full rises. The full 27-way keyword compare is
// combinational, so a token is classified when the byte after it arrives.
// An end_of_input beat flushes any pending token and then gives the end
// token; scanning then resumes with line and offset counters kept. Every
// token carries kind, start line (saturating), start offset and length
// (saturating); last marks the final token caused by a beat.
// ----------------------------------------------------------------------------
module pascal_subset_lexer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  psl_pkg::in_item_t  char_item,
    output logic               empty,
    input  logic               pop,
    output psl_pkg::token_t    token
);

    logic            accept;
    logic            q_wr_en, q_rd_en, q_empty;
    psl_pkg::entry_t q_wr_data, q_head;

    // Accept a beat whenever the queue has room.
    assign accept = push && !full;

    psl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (char_item),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data)
    );

    // Hold classified entries so the scanner and the consumer stall apart.
    psl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (full),
        .rd_en   (q_rd_en),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    psl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_rd_en (q_rd_en),
        .pop     (pop),
        .empty   (empty),
        .token   (token)
    );

endmodule

FILE: src/psl_checker.sv
// ----------------------------------------------------------------------------
// psl_checker
// Port-level checks on the token stream of the lexer.
// ----------------------------------------------------------------------------
`include "pascal_subset_lexer_assert.svh"

module psl_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            pop,
    input logic            empty,
    input psl_pkg::token_t token
);

    `PSL_ASSERT_NEXT(a_hold_stalled, !empty && !pop, !empty && $stable(token))
    `PSL_ASSERT_NOW(a_end_shape, !empty && token.token_kind == psl_pkg::K_END, token.token_length == '0 && !token.unclosed_comment && token.last)
    `PSL_ASSERT_NOW(a_unclosed_unknown, !empty && token.unclosed_comment, token.token_kind == psl_pkg::K_UNKNOWN)
    `PSL_ASSERT_NOW(a_len_zero_end, !empty && token.token_length == '0, token.token_kind == psl_pkg::K_END)

endmodule

bind pascal_subset_lexer psl_checker u_psl_checker (.*);

FILE: verif/tb_pascal_subset_lexer.sv
// ----------------------------------------------------------------------------
// tb_pascal_subset_lexer
// Self-checking bench: bytes go in through push/full, and tokens come out
// through empty/pop. Each token is checked against a token predictor that
// runs inside this bench.
// ----------------------------------------------------------------------------
// A directed source text comes first: keywords, every operator, the number
// corner cases, quoted items, both comment forms, bytes with no meaning and
// end-of-input flushes. After it comes a random source text built from
// well-formed and malformed fragments, noise bytes and end flags. The sender
// pushes in bursts with random gaps. The receiver stalls on a duty pattern
// of its own, and that pattern changes from time to time.
// ----------------------------------------------------------------------------
module tb_pascal_subset_lexer;

    localparam int RANDOM_BYTES = 1050;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [4:0] {
        SM_IDLE, SM_WORD, SM_INT, SM_INT_DOT, SM_REAL, SM_BAD, SM_DOT, SM_STR,
        SM_BRACE, SM_LPAREN, SM_PCMT, SM_PCMT_STAR, SM_EQ, SM_COLON, SM_LT, SM_GT
    } scan_mode_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    psl_pkg::in_item_t  char_item;
    logic               empty;
    logic               pop;
    psl_pkg::token_t    token;

    pascal_subset_lexer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_item (char_item),
        .empty     (empty),
        .pop       (pop),
        .token     (token)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Token predictor state
    // ------------------------------------------------------------------
    string kw_words [27] = '{
        "not", "div", "mod", "and", "or", "const", "type", "var", "function",
        "procedure", "array", "record", "program", "begin", "if", "case",
        "repeat", "while", "for", "end", "else", "until", "of", "do", "to",
        "downto", "then"
    };

    scan_mode_t                      mode;
    logic [psl_pkg::LINE_BITS-1:0]   cur_line;
    logic [31:0]                     cur_off;
    logic [psl_pkg::LINE_BITS-1:0]   tok_line;
    logic [31:0]                     tok_off;
    logic [psl_pkg::LENGTH_BITS-1:0] tok_len;
    logic [7:0]                      word_chars [psl_pkg::KW_MAX_LEN];
    int                              quote_n;

    psl_pkg::token_t   beat_tokens [$];  // tokens caused by the beat being predicted
    psl_pkg::token_t   expected_tokens [$];
    psl_pkg::in_item_t source_beats [$];

    int  mismatch_count = 0;
    int  tokens_checked = 0;
    int  beats_taken = 0;
    int  end_flags = 0;
    int  cycle_count = 0;
    bit  running = 0;

    function automatic void add_token(logic [psl_pkg::KIND_BITS-1:0] kind,
                                      logic [psl_pkg::LINE_BITS-1:0] line,
                                      logic [31:0] off,
                                      logic [psl_pkg::LENGTH_BITS-1:0] len,
                                      logic unc);
        psl_pkg::token_t t;
        t.token_kind       = kind;
        t.start_line       = line;
        t.start_offset     = off;
        t.token_length     = len;
        t.unclosed_comment = unc;
        t.last             = 1'b0;
        beat_tokens.insert(beat_tokens.size(), t);
    endfunction

    function automatic void flush_pending(logic [psl_pkg::KIND_BITS-1:0] kind, logic unc);
        add_token(kind, tok_line, tok_off, tok_len, unc);
    endfunction

    function automatic void lengthen();
        if (tok_len != '1)
            tok_len = tok_len + 1'b1;
    endfunction

    function automatic void open_token(scan_mode_t m, logic [psl_pkg::LINE_BITS-1:0] line,
                                       logic [31:0] off);
        mode     = m;
        tok_line = line;
        tok_off  = off;
        tok_len  = 1;
    endfunction

    function automatic bit letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Match the buffered word against the keyword list; identifier otherwise.
    function automatic logic [psl_pkg::KIND_BITS-1:0] word_class();
        bit same;
        if (tok_len > psl_pkg::KW_MAX_LEN)
            return psl_pkg::K_IDENT;
        for (int k = 0; k < 27; k++)
        begin
            if (kw_words[k].len() == tok_len)
            begin
                same = 1;
                for (int i = 0; i < kw_words[k].len(); i++)
                    if (kw_words[k][i] != word_chars[i])
                        same = 0;
                if (same)
                    return psl_pkg::KIND_BITS'(k + 1);
            end
        end
        return psl_pkg::K_IDENT;
    endfunction

    function automatic void start_scan(logic [7:0] c, logic [psl_pkg::LINE_BITS-1:0] line,
                                       logic [31:0] off);
        mode = SM_IDLE;
        if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D)
            return;
        if (letter(c))
        begin
            open_token(SM_WORD, line, off);
            word_chars[0] = fold_case(c);
            return;
        end
        if (numeral(c))
        begin
            open_token(SM_INT, line, off);
            return;
        end
        case (c)
            "'":
            begin
                open_token(SM_STR, line, off);
                quote_n = 0;
            end
            "{": open_token(SM_BRACE, line, off);
            "(": open_token(SM_LPAREN, line, off);
            "=": open_token(SM_EQ, line, off);
            ":": open_token(SM_COLON, line, off);
            "<": open_token(SM_LT, line, off);
            ">": open_token(SM_GT, line, off);
            ".": open_token(SM_DOT, line, off);
            "+": add_token(psl_pkg::K_PLUS, line, off, 1, 0);
            "-": add_token(psl_pkg::K_MINUS, line, off, 1, 0);
            "*": add_token(psl_pkg::K_TIMES, line, off, 1, 0);
            "/": add_token(psl_pkg::K_RDIV, line, off, 1, 0);
            ")": add_token(psl_pkg::K_RPAR, line, off, 1, 0);
            "[": add_token(psl_pkg::K_LBRACK, line, off, 1, 0);
            "]": add_token(psl_pkg::K_RBRACK, line, off, 1, 0);
            ",": add_token(psl_pkg::K_COMMA, line, off, 1, 0);
            ";": add_token(psl_pkg::K_SEMI, line, off, 1, 0);
            default: add_token(psl_pkg::K_UNKNOWN, line, off, 1, 0);
        endcase
    endfunction

    function automatic void malformed_step(logic [7:0] c, logic [psl_pkg::LINE_BITS-1:0] line,
                                           logic [31:0] off);
        if (letter(c) || numeral(c) || c == "." || c == "+" || c == "-" || c == "/")
            lengthen();
        else
        begin
            flush_pending(psl_pkg::K_UNKNOWN, 0);
            start_scan(c, line, off);
        end
    endfunction

    function automatic void operator_step(logic [7:0] c, logic [psl_pkg::LINE_BITS-1:0] line,
                                          logic [31:0] off, logic [7:0] c1,
                                          logic [psl_pkg::KIND_BITS-1:0] k1, logic [7:0] c2,
                                          logic [psl_pkg::KIND_BITS-1:0] k2,
                                          logic [psl_pkg::KIND_BITS-1:0] lone);
        if (c == c1 || c == c2)
        begin
            lengthen();
            flush_pending(c == c1 ? k1 : k2, 0);
            mode = SM_IDLE;
        end
        else
        begin
            flush_pending(lone, 0);
            start_scan(c, line, off);
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic [psl_pkg::LINE_BITS-1:0] line;
        logic [31:0]                   off;
        line = cur_line;
        off  = cur_off;
        case (mode)
            SM_WORD:
                if (letter(c) || numeral(c))
                begin
                    if (tok_len < psl_pkg::KW_MAX_LEN)
                        word_chars[tok_len] = fold_case(c);
                    lengthen();
                end
                else
                begin
                    flush_pending(word_class(), 0);
                    start_scan(c, line, off);
                end
            SM_INT:
                if (numeral(c))
                    lengthen();
                else if (c == ".")
                    mode = SM_INT_DOT;
                else
                begin
                    flush_pending(psl_pkg::K_INT, 0);
                    start_scan(c, line, off);
                end
            SM_INT_DOT:
                if (c == ".")
                begin
                    // number then range: split into integer and period
                    flush_pending(psl_pkg::K_INT, 0);
                    add_token(psl_pkg::K_PERIOD, line, off - 1, 1, 0);
                    open_token(SM_DOT, line, off);
                end
                else if (numeral(c))
                begin
                    lengthen();
                    lengthen();
                    mode = SM_REAL;
                end
                else
                begin
                    lengthen();
                    mode = SM_BAD;
                    malformed_step(c, line, off);
                end
            SM_REAL:
                if (numeral(c))
                    lengthen();
                else if (c == "." || letter(c))
                begin
                    lengthen();
                    mode = SM_BAD;
                end
                else
                begin
                    flush_pending(psl_pkg::K_REAL, 0);
                    start_scan(c, line, off);
                end
            SM_BAD: malformed_step(c, line, off);
            SM_DOT:
                if (numeral(c))
                begin
                    lengthen();
                    mode = SM_BAD;
                end
                else
                begin
                    flush_pending(psl_pkg::K_PERIOD, 0);
                    start_scan(c, line, off);
                end
            SM_STR:
            begin
                lengthen();
                if (c == "'")
                begin
                    flush_pending(quote_n == 0 ? psl_pkg::K_UNKNOWN :
                                  (quote_n == 1 ? psl_pkg::K_CHAR : psl_pkg::K_STRING), 0);
                    mode = SM_IDLE;
                end
                else if (quote_n < 2)
                    quote_n++;
            end
            SM_BRACE:
            begin
                lengthen();
                if (c == "}")
                    mode = SM_IDLE;
            end
            SM_LPAREN:
                if (c == "*")
                begin
                    lengthen();
                    mode = SM_PCMT;
                end
                else
                begin
                    flush_pending(psl_pkg::K_LPAR, 0);
                    start_scan(c, line, off);
                end
            SM_PCMT:
            begin
                lengthen();
                if (c == "*")
                    mode = SM_PCMT_STAR;
            end
            SM_PCMT_STAR:
            begin
                lengthen();
                if (c == ")")
                    mode = SM_IDLE;
                else if (c != "*")
                    mode = SM_PCMT;
            end
            SM_EQ:    operator_step(c, line, off, "=", psl_pkg::K_EQL, "=", psl_pkg::K_EQL,
                                    psl_pkg::K_UNKNOWN);
            SM_COLON: operator_step(c, line, off, "=", psl_pkg::K_BECOMES, "=",
                                    psl_pkg::K_BECOMES, psl_pkg::K_COLON);
            SM_LT:    operator_step(c, line, off, ">", psl_pkg::K_NEQ, "=", psl_pkg::K_LEQ,
                                    psl_pkg::K_LSS);
            SM_GT:    operator_step(c, line, off, "=", psl_pkg::K_GEQ, "=", psl_pkg::K_GEQ,
                                    psl_pkg::K_GTR);
            default:  start_scan(c, line, off);
        endcase
        if (c == 8'h0A && cur_line != '1)
            cur_line = cur_line + 1'b1;
        cur_off = cur_off + 1;
    endfunction

    function automatic void scan_end();
        case (mode)
            SM_WORD:    flush_pending(word_class(), 0);
            SM_INT:     flush_pending(psl_pkg::K_INT, 0);
            SM_INT_DOT:
            begin
                lengthen();
                flush_pending(psl_pkg::K_UNKNOWN, 0);
            end
            SM_REAL:    flush_pending(psl_pkg::K_REAL, 0);
            SM_BAD, SM_STR, SM_EQ: flush_pending(psl_pkg::K_UNKNOWN, 0);
            SM_DOT:     flush_pending(psl_pkg::K_PERIOD, 0);
            SM_BRACE, SM_PCMT, SM_PCMT_STAR: flush_pending(psl_pkg::K_UNKNOWN, 1);
            SM_LPAREN:  flush_pending(psl_pkg::K_LPAR, 0);
            SM_COLON:   flush_pending(psl_pkg::K_COLON, 0);
            SM_LT:      flush_pending(psl_pkg::K_LSS, 0);
            SM_GT:      flush_pending(psl_pkg::K_GTR, 0);
            default: ;
        endcase
        add_token(psl_pkg::K_END, cur_line, cur_off, 0, 0);
        mode = SM_IDLE;
    endfunction

    // Work out the tokens of one accepted beat, mark the final one as last,
    // and queue them as expectations.
    function automatic void predict_tokens(psl_pkg::in_item_t it);
        beat_tokens.delete();
        if (it.end_of_input)
            scan_end();
        else
            scan_byte(it.char_code);
        if (beat_tokens.size() > 0)
            beat_tokens[beat_tokens.size() - 1].last = 1'b1;
        foreach (beat_tokens[i])
            expected_tokens.insert(expected_tokens.size(), beat_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // Source text builders
    // ------------------------------------------------------------------
    task automatic put_byte(logic [7:0] c);
        psl_pkg::in_item_t it;
        it.char_code    = c;
        it.end_of_input = 1'b0;
        source_beats.insert(source_beats.size(), it);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_end();
        psl_pkg::in_item_t it;
        // the byte field is ignored on an end beat, so fill it with noise
        it.char_code    = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        source_beats.insert(source_beats.size(), it);
    endtask

    task automatic put_digits(int n);
        for (int i = 0; i < n; i++)
            put_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    // Write a keyword with random upper and lower case letters.
    task automatic put_keyword(string w);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++)
        begin
            c = w[i];
            put_byte($urandom_range(0, 1) ? c - 8'd32 : c);
        end
    endtask

    task automatic put_fragment();
        int pick;
        int n;
        logic [7:0] c;
        string ops [16] = '{"+", "-", "*", "/", "==", "=", "<>", "<", "<=", ">", ">=",
                            ":=", ":", "(", ")", "[]"};
        string seps [5] = '{" ", "\t", "\n", "\r", ",;"};
        pick = $urandom_range(0, 15);
        case (pick)
            0, 1: put_keyword(kw_words[$urandom_range(0, 26)]);
            2:
            begin
                n = $urandom_range(1, 12);
                put_byte(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
                                                 : "A" + $urandom_range(0, 25)));
                for (int i = 1; i < n; i++)
                begin
                    case ($urandom_range(0, 2))
                        0: c = 8'("a" + $urandom_range(0, 25));
                        1: c = 8'("A" + $urandom_range(0, 25));
                        default: c = 8'("0" + $urandom_range(0, 9));
                    endcase
                    put_byte(c);
                end
            end
            3: put_digits($urandom_range(1, 6));
            4:
            begin
                put_digits($urandom_range(1, 4));
                put_byte(".");
                put_digits($urandom_range(1, 4));
            end
            5:
            begin
                put_digits($urandom_range(1, 3));
                put_text("..");
                put_digits($urandom_range(0, 3));
            end
            6:
            begin
                // malformed numbers of several shapes
                case ($urandom_range(0, 3))
                    0: begin put_digits(2); put_text(".x"); put_digits(1); end
                    1: begin put_digits(1); put_text(".5.e+1-2/"); end
                    2: begin put_text(".7a"); end
                    default: begin put_digits(1); put_text(".2q"); end
                endcase
            end
            7:
            begin
                put_byte("'");
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    c = 8'($urandom_range(0, 255));
                    put_byte(c == "'" ? 8'h41 : c);
                end
                if ($urandom_range(0, 9) != 0)
                    put_byte("'");
            end
            8:
            begin
                put_byte("{");
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                begin
                    c = 8'($urandom_range(0, 255));
                    put_byte(c == "}" ? 8'h0A : c);
                end
                if ($urandom_range(0, 7) != 0)
                    put_byte("}");
            end
            9:
            begin
                put_text("(*");
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                    put_byte($urandom_range(0, 2) == 0 ? "*" : 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) != 0)
                    put_text("*)");
            end
            10, 11: put_text(ops[$urandom_range(0, 15)]);
            12: put_byte(8'($urandom_range(0, 255)));
            13: put_text(".");
            14: if ($urandom_range(0, 2) == 0) put_end();
            default: put_text(seps[$urandom_range(0, 4)]);
        endcase
        // words and numbers run into each other now and then
        if ($urandom_range(0, 3) != 0)
            put_text(seps[$urandom_range(0, 4)]);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of pushes separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (running)
        begin
            if (gap_left > 0)
            begin
                push <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (source_beats.size() > 0)
            begin
                push      <= 1'b1;
                char_item <= source_beats[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver: pop high while the phase is below the duty in every period;
    // both change every so often, and sometimes the duty covers the whole period.
    int stall_period = 1;
    int stall_duty = 1;
    int stall_phase = 0;

    always @(negedge clk)
    begin
        if (running)
        begin
            pop <= (stall_phase < stall_duty);
            if (stall_phase + 1 >= stall_period)
            begin
                stall_phase <= 0;
                if ($urandom_range(0, 15) == 0)
                begin
                    stall_period <= $urandom_range(1, 8);
                    stall_duty   <= $urandom_range(0, 3) == 0 ? 8 : $urandom_range(1, 7);
                end
            end
            else
                stall_phase <= stall_phase + 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take accepted beats into the predictor, check popped tokens
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        psl_pkg::token_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_tokens(char_item);
                if (char_item.end_of_input)
                    end_flags++;
                beats_taken++;
                void'(source_beats.pop_front());
            end
            if (pop && !empty)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("token with no expectation: kind %0d offset %0d",
                           token.token_kind, token.start_offset);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    tokens_checked++;
                    if (token.token_kind != want.token_kind)
                    begin
                        $error("token_kind expected %0d got %0d",
                               want.token_kind, token.token_kind);
                        mismatch_count++;
                    end
                    if (token.start_line != want.start_line)
                    begin
                        $error("start_line expected %0d got %0d",
                               want.start_line, token.start_line);
                        mismatch_count++;
                    end
                    if (token.start_offset != want.start_offset)
                    begin
                        $error("start_offset expected %0d got %0d",
                               want.start_offset, token.start_offset);
                        mismatch_count++;
                    end
                    if (token.token_length != want.token_length)
                    begin
                        $error("token_length expected %0d got %0d",
                               want.token_length, token.token_length);
                        mismatch_count++;
                    end
                    if (token.unclosed_comment != want.unclosed_comment)
                    begin
                        $error("unclosed_comment expected %0d got %0d",
                               want.unclosed_comment, token.unclosed_comment);
                        mismatch_count++;
                    end
                    if (token.last != want.last)
                    begin
                        $error("last expected %0d got %0d", want.last, token.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Give up on a hang.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens still expected",
                     cycle_count, expected_tokens.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Source text, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int random_start;
        clk       = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        char_item = '0;

        mode     = SM_IDLE;
        cur_line = 1;
        cur_off  = 0;
        tok_line = 1;
        tok_off  = 0;
        tok_len  = 0;
        quote_n  = 0;
        foreach (word_chars[i])
            word_chars[i] = 8'h00;

        // Directed part: keywords in mixed case, numbers and the range case,
        // malformed numbers, quoted items, comments, operators, odd bytes.
        put_text("PROCEDURE downto Begin\n");
        put_text("x1 := 12..34; 3.14 7.x 1.5. .5 2.e\n");
        put_text("'' 'a' 'abc' == = <> <= >= < > : (x) [*/+-] ,\t\r");
        put_text("{ c } (* d *) (*) *) x");
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h80);
        put_text("12.");
        put_end();
        put_text("(*");
        put_end();
        put_end();
        put_text("'ab");
        put_end();
        put_text("<");
        put_end();

        random_start = source_beats.size();
        while (source_beats.size() - random_start < RANDOM_BYTES)
            put_fragment();
        put_end();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n   = 1'b1;
        running = 1'b1;

        while (source_beats.size() != 0 || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_tokens.size() != 0)
        begin
            $error("%0d expected tokens never arrived", expected_tokens.size());
            mismatch_count++;
        end

        $display("covered %0d byte and end beats (%0d end flags), checked %0d tokens",
                 beats_taken, end_flags, tokens_checked);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
